FILE: design/oil_paint_filter_3x3_top_defines.svh
// Assertion macros shared by the checker of the oil painting filter.
// No dependencies; the including file must provide i_clk and i_rst_n.
`ifndef OIL_PAINT_FILTER_3X3_TOP_DEFINES_SVH
`define OIL_PAINT_FILTER_3X3_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define OPF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define OPF_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: design/opf_pkg.sv
// Types, constants and the small reciprocal table of the oil painting filter.
// No dependencies.
package opf_pkg;

    localparam int unsigned NUM_PIX = 9;
    localparam int unsigned CENTRE  = 4;

    typedef logic [7:0] t_chan;
    typedef logic [7:0] t_luma;
    typedef logic [3:0] t_count;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    // Luma weights scaled by 10000; the weighted sum fits in 22 bits.
    localparam int unsigned SUM_W = 22;
    localparam logic [SUM_W-1:0] W_RED   = 22'd2989;
    localparam logic [SUM_W-1:0] W_GREEN = 22'd5870;
    localparam logic [SUM_W-1:0] W_BLUE  = 22'd1140;

    // Division by 10000 as a multiply by ceil(2^36 / 10000), exact below 2^22.
    localparam int unsigned LUMA_SHIFT = 36;
    localparam int unsigned PROD_W     = 45;
    localparam logic [PROD_W-1:0] LUMA_RECIP = 45'd6871948;

    // Channel sums over nine pixels fit in 12 bits.
    localparam int unsigned CSUM_W    = 12;
    localparam int unsigned AVG_SHIFT = 16;
    localparam int unsigned RECIP_W   = 17;
    localparam int unsigned AVG_W     = CSUM_W + RECIP_W;

    typedef logic [CSUM_W-1:0]  t_csum;
    typedef logic [RECIP_W-1:0] t_recip;

    // ceil(2^16 / n) for a mode count of 1 to 9; exact for sums below 2^12.
    function automatic t_recip avg_recip(input t_count n);
        t_recip r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

FILE: design/opf_luma.sv
// Two-stage luma unit: weighted sum, then division by 10000 by reciprocal.
// Depends on opf_pkg.
module opf_luma (
    input  logic          i_clk,
    input  opf_pkg::t_rgb i_pixel,
    output opf_pkg::t_luma o_luma
);
    import opf_pkg::*;

    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] w_prod;
    t_luma             n_luma;
    t_luma             r_luma;

    // Weighted sum of the three channels.
    always_comb begin
        n_sum = SUM_W'(i_pixel.red)   * W_RED
              + SUM_W'(i_pixel.green) * W_GREEN
              + SUM_W'(i_pixel.blue)  * W_BLUE;
    end

    // Truncating division by 10000; the quotient never exceeds 254.
    assign w_prod = PROD_W'(r_sum) * LUMA_RECIP;
    assign n_luma = w_prod[LUMA_SHIFT+7:LUMA_SHIFT];

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_luma <= n_luma;
    end

    assign o_luma = r_luma;

endmodule

FILE: design/oil_paint_filter_3x3_top.sv
// Top level of the 3x3 oil painting filter with luma mode selection.
// Depends on opf_pkg and opf_luma.
//
//  Channel | Handshake          | Payload
//  --------+--------------------+------------------------------------------------
//  window  | start / busy       | i_pixel_top_left .. i_pixel_bottom_right, i_is_border
//  result  | o_strobe (1 cycle) | o_out_red, o_out_green, o_out_blue, o_mode_luma
//
// A seven-stage pipeline: a window beat may be accepted in every cycle and its
// result strobes as it leaves the last stage. busy is never raised, as nothing stalls.
// The stages are luma sum, luma division, match counts, two levels of the mode
// search, channel sums, and the reciprocal multiply for the average.
// Synchronous active-low reset clears the valid bits only.
module oil_paint_filter_3x3_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [23:0]   i_pixel_top_left,
    input  logic [23:0]   i_pixel_top,
    input  logic [23:0]   i_pixel_top_right,
    input  logic [23:0]   i_pixel_left,
    input  logic [23:0]   i_pixel_center,
    input  logic [23:0]   i_pixel_right,
    input  logic [23:0]   i_pixel_bottom_left,
    input  logic [23:0]   i_pixel_bottom,
    input  logic [23:0]   i_pixel_bottom_right,
    input  logic          i_is_border,
    output logic          o_strobe,
    output logic [7:0]    o_out_red,
    output logic [7:0]    o_out_green,
    output logic [7:0]    o_out_blue,
    output logic [7:0]    o_mode_luma
);
    import opf_pkg::*;

    localparam int unsigned KEY_W  = 12;
    localparam int unsigned GROUPS = 3;

    typedef logic [KEY_W-1:0] t_key;

    t_rgb   w_win [NUM_PIX];
    t_luma  w_lum [NUM_PIX];

    logic   r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic   r_bdr1, r_bdr2, r_bdr3, r_bdr4, r_bdr5;
    t_rgb   r_px1 [NUM_PIX];
    t_rgb   r_px2 [NUM_PIX];
    t_rgb   r_px3 [NUM_PIX];
    t_rgb   r_px4 [NUM_PIX];
    t_rgb   r_px5 [NUM_PIX];
    t_luma  r_lum3 [NUM_PIX];
    t_luma  r_lum4 [NUM_PIX];
    t_luma  r_lum5 [NUM_PIX];
    t_count n_cnt3 [NUM_PIX];
    t_count r_cnt3 [NUM_PIX];
    t_key   n_key4 [GROUPS];
    t_key   r_key4 [GROUPS];
    t_luma  n_best5;
    t_luma  r_best5;
    t_csum  n_rsum, n_gsum, n_bsum;
    t_csum  r_rsum, r_gsum, r_bsum;
    t_count n_n6, r_n6;
    t_luma  n_mode6, r_mode6;
    t_recip w_recip;
    logic [AVG_W-1:0] w_rprod, w_gprod, w_bprod;
    t_chan  r_red, r_green, r_blue;
    t_luma  r_mode7;

    // The window in row order; the centre sits at index CENTRE.
    assign w_win[0] = i_pixel_top_left;
    assign w_win[1] = i_pixel_top;
    assign w_win[2] = i_pixel_top_right;
    assign w_win[3] = i_pixel_left;
    assign w_win[4] = i_pixel_center;
    assign w_win[5] = i_pixel_right;
    assign w_win[6] = i_pixel_bottom_left;
    assign w_win[7] = i_pixel_bottom;
    assign w_win[8] = i_pixel_bottom_right;

    assign busy = 1'b0;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    // Stages one and two: the luma of every pixel.
    for (genvar g = 0; g < NUM_PIX; g++) begin : g_luma
        opf_luma u_luma (
            .i_clk   (i_clk),
            .i_pixel (w_win[g]),
            .o_luma  (w_lum[g])
        );
    end

    // Stage three: how many pixels share each pixel's luma.
    always_comb begin
        for (int i = 0; i < NUM_PIX; i++) begin
            n_cnt3[i] = '0;
            for (int k = 0; k < NUM_PIX; k++) begin
                n_cnt3[i] = n_cnt3[i] + t_count'(w_lum[k] == w_lum[i]);
            end
        end
    end

    // Stage four: best of each group of three; the key ranks a higher count first,
    // then a smaller luma.
    always_comb begin
        t_key ka, kb, kc, kab;
        for (int g = 0; g < GROUPS; g++) begin
            ka  = {r_cnt3[3*g],   ~r_lum3[3*g]};
            kb  = {r_cnt3[3*g+1], ~r_lum3[3*g+1]};
            kc  = {r_cnt3[3*g+2], ~r_lum3[3*g+2]};
            kab = (kb > ka) ? kb : ka;
            n_key4[g] = (kc > kab) ? kc : kab;
        end
    end

    // Stage five: the mode over the three group winners.
    always_comb begin
        t_key k01, kbest;
        k01     = (r_key4[1] > r_key4[0]) ? r_key4[1] : r_key4[0];
        kbest   = (r_key4[2] > k01) ? r_key4[2] : k01;
        n_best5 = ~kbest[7:0];
    end

    // Stage six: channel sums over the pixels that carry the mode. A border
    // centre passes through as a single pixel of its own luma.
    always_comb begin
        n_rsum  = '0;
        n_gsum  = '0;
        n_bsum  = '0;
        n_n6    = '0;
        n_mode6 = r_best5;
        if (r_bdr5) begin
            n_rsum  = t_csum'(r_px5[CENTRE].red);
            n_gsum  = t_csum'(r_px5[CENTRE].green);
            n_bsum  = t_csum'(r_px5[CENTRE].blue);
            n_n6    = t_count'(1);
            n_mode6 = r_lum5[CENTRE];
        end else begin
            for (int i = 0; i < NUM_PIX; i++) begin
                if (r_lum5[i] == r_best5) begin
                    n_rsum = n_rsum + t_csum'(r_px5[i].red);
                    n_gsum = n_gsum + t_csum'(r_px5[i].green);
                    n_bsum = n_bsum + t_csum'(r_px5[i].blue);
                    n_n6   = n_n6 + t_count'(1);
                end
            end
        end
    end

    // Stage seven: truncating average by a reciprocal multiply.
    assign w_recip = avg_recip(r_n6);
    assign w_rprod = AVG_W'(r_rsum) * AVG_W'(w_recip);
    assign w_gprod = AVG_W'(r_gsum) * AVG_W'(w_recip);
    assign w_bprod = AVG_W'(r_bsum) * AVG_W'(w_recip);

    // Pipeline data registers; no reset needed.
    always_ff @(posedge i_clk) begin
        r_bdr1 <= i_is_border;
        r_bdr2 <= r_bdr1;
        r_bdr3 <= r_bdr2;
        r_bdr4 <= r_bdr3;
        r_bdr5 <= r_bdr4;
        for (int i = 0; i < NUM_PIX; i++) begin
            r_px1[i]  <= w_win[i];
            r_px2[i]  <= r_px1[i];
            r_px3[i]  <= r_px2[i];
            r_px4[i]  <= r_px3[i];
            r_px5[i]  <= r_px4[i];
            r_lum3[i] <= w_lum[i];
            r_lum4[i] <= r_lum3[i];
            r_lum5[i] <= r_lum4[i];
            r_cnt3[i] <= n_cnt3[i];
        end
        for (int g = 0; g < GROUPS; g++) begin
            r_key4[g] <= n_key4[g];
        end
        r_best5 <= n_best5;
        r_rsum  <= n_rsum;
        r_gsum  <= n_gsum;
        r_bsum  <= n_bsum;
        r_n6    <= n_n6;
        r_mode6 <= n_mode6;
        r_red   <= w_rprod[AVG_SHIFT+7:AVG_SHIFT];
        r_green <= w_gprod[AVG_SHIFT+7:AVG_SHIFT];
        r_blue  <= w_bprod[AVG_SHIFT+7:AVG_SHIFT];
        r_mode7 <= r_mode6;
    end

    assign o_strobe    = r_v7;
    assign o_out_red   = r_red;
    assign o_out_green = r_green;
    assign o_out_blue  = r_blue;
    assign o_mode_luma = r_mode7;

endmodule

FILE: design/opf_checker.sv
// Port-level checks on the oil painting filter, bound to its top level.
// Depends on oil_paint_filter_3x3_top_defines.svh.
`include "oil_paint_filter_3x3_top_defines.svh"

module opf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [23:0] i_pixel_top_left,
    input logic [23:0] i_pixel_top,
    input logic [23:0] i_pixel_top_right,
    input logic [23:0] i_pixel_left,
    input logic [23:0] i_pixel_center,
    input logic [23:0] i_pixel_right,
    input logic [23:0] i_pixel_bottom_left,
    input logic [23:0] i_pixel_bottom,
    input logic [23:0] i_pixel_bottom_right,
    input logic        i_is_border,
    input logic        o_strobe,
    input logic [7:0]  o_out_red,
    input logic [7:0]  o_out_green,
    input logic [7:0]  o_out_blue,
    input logic [7:0]  o_mode_luma
);

    logic w_acc;
    logic w_uniform;

    assign w_acc = start && !busy;

    // A window whose nine pixels are all the same colour.
    assign w_uniform = (i_pixel_top_left == i_pixel_center)
                    && (i_pixel_top == i_pixel_center)
                    && (i_pixel_top_right == i_pixel_center)
                    && (i_pixel_left == i_pixel_center)
                    && (i_pixel_right == i_pixel_center)
                    && (i_pixel_bottom_left == i_pixel_center)
                    && (i_pixel_bottom == i_pixel_center)
                    && (i_pixel_bottom_right == i_pixel_center);

    // Every result beat stems from an accepted window beat.
    `OPF_ASSERT_NEVER(a_no_spurious, o_strobe && !$past(w_acc, 7), "result without window beat")

    // A window beat taken out of reset always yields its result.
    `OPF_ASSERT_IMPL(a_no_loss, $past(w_acc, 7) && $past(i_rst_n, 7) && $past(i_rst_n, 6) && $past(i_rst_n, 5) && $past(i_rst_n, 4) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1), o_strobe, "window beat lost")

    // A border centre comes out unchanged.
    `OPF_ASSERT_IMPL(a_border_pass, o_strobe && $past(i_is_border, 7), {o_out_red, o_out_green, o_out_blue} == $past(i_pixel_center, 7), "border pixel altered")

    // A flat window averages to its own colour.
    `OPF_ASSERT_IMPL(a_flat_window, o_strobe && $past(w_uniform, 7), {o_out_red, o_out_green, o_out_blue} == $past(i_pixel_center, 7), "flat window altered")

endmodule

bind oil_paint_filter_3x3_top opf_checker u_opf_checker (.*);
